// File: rtl/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is asserted.
`define BPDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that also runs through reset.
`define BPDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/bpdc_pkg.sv
// Package of the button press duration classifier: defaults, codes and register indexes.
package bpdc_pkg;

  // Default geometry
  localparam int unsigned NUM_BUTTONS_DEF = 4;
  localparam int unsigned TIME_WIDTH_DEF  = 32;

  // Request field and configuration port widths
  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned THR_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = THR_W;

  // Threshold reset values, in time units
  localparam logic [THR_W-1:0] THR_SHORT_RST = 32'd50;
  localparam logic [THR_W-1:0] THR_LONG_RST  = 32'd1000;

  // Request codes; the fourth code is unused and leaves the state alone
  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_SAMPLE     = 2'd0,
    REQ_READ_SHORT = 2'd1,
    REQ_READ_LONG  = 2'd2
  } req_type_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_THR = 1'b0,
    REG_LONG_THR  = 1'b1
  } cfg_reg_e;

endpackage

// File: rtl/bpdc_if.sv
// Valid/ready channel interfaces of the button press duration classifier.

// Request channel: samples and read-and-clear requests
interface bpdc_req_if #(
  parameter int unsigned NUM_BUTTONS = bpdc_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned TIME_WIDTH  = bpdc_pkg::TIME_WIDTH_DEF
) ();
  logic                                  valid;
  logic                                  ready;
  logic [bpdc_pkg::REQ_TYPE_W-1:0]       req_type;
  logic [NUM_BUTTONS-1:0]                button_levels;
  logic [TIME_WIDTH-1:0]                 time_now;
  logic [NUM_BUTTONS-1:0]                button_mask;

  modport source (output valid, req_type, button_levels, time_now, button_mask,
                  input ready);
  modport sink   (input valid, req_type, button_levels, time_now, button_mask,
                  output ready);
endinterface

// Result channel: one item per request
interface bpdc_rsp_if #(
  parameter int unsigned NUM_BUTTONS = bpdc_pkg::NUM_BUTTONS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   all_flagged;
  logic [NUM_BUTTONS-1:0] short_flags;
  logic [NUM_BUTTONS-1:0] long_flags;
  logic [NUM_BUTTONS-1:0] held_buttons;

  modport source (output valid, all_flagged, short_flags, long_flags, held_buttons,
                  input ready);
  modport sink   (input valid, all_flagged, short_flags, long_flags, held_buttons,
                  output ready);
endinterface

// Configuration write channel
interface bpdc_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [bpdc_pkg::CFG_IDX_W-1:0]  index;
  logic [bpdc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/button_press_duration_classifier.sv
// Top level of the button press duration classifier.
// The block takes one request item per clock and returns one result item for each, in
// order. An accepted item waits in the input register until the result register is free
// or being emptied; it is then applied to the held mask, the press stamps and the
// short and long flags and loads the result register, from which the result is taken.
// The sustained rate is one item per cycle, set by the single state-update step between
// the two registers; req.ready drops only while both registers are full and the
// result is not taken. Configuration writes are taken in every cycle.
module button_press_duration_classifier #(
  parameter int unsigned NUM_BUTTONS = bpdc_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned TIME_WIDTH  = bpdc_pkg::TIME_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpdc_req_if.sink   req,
  bpdc_rsp_if.source rsp,
  bpdc_cfg_if.sink   cfg
);
  import bpdc_pkg::*;

  // Width at which held times and thresholds are compared
  localparam int unsigned CMP_W = (TIME_WIDTH > THR_W) ? TIME_WIDTH : THR_W;

  logic [THR_W-1:0]       thr_short_q, thr_long_q;

  logic                   s1_valid_q;
  logic [REQ_TYPE_W-1:0]  s1_type_q;
  logic [NUM_BUTTONS-1:0] s1_levels_q;
  logic [TIME_WIDTH-1:0]  s1_time_q;
  logic [NUM_BUTTONS-1:0] s1_mask_q;

  logic [NUM_BUTTONS-1:0] held_q, held_d;
  logic [NUM_BUTTONS-1:0] short_q, short_d;
  logic [NUM_BUTTONS-1:0] long_q, long_d;
  logic [TIME_WIDTH-1:0]  stamp_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] stamp_we;
  logic                   all_d;

  logic [TIME_WIDTH-1:0]  held_time [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] long_hit, short_hit;

  logic                   out_valid_q;
  logic                   out_all_q;
  logic [NUM_BUTTONS-1:0] out_short_q, out_long_q, out_held_q;

  logic                   adv;
  logic                   in_ready;
  logic                   in_acc;

  // Handshake: stage 1 moves on when the result register is free or being emptied
  assign adv      = s1_valid_q && (!out_valid_q || rsp.ready);
  assign in_ready = !s1_valid_q || adv;
  assign in_acc   = req.valid && in_ready;
  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_short_q <= THR_SHORT_RST;
      thr_long_q  <= THR_LONG_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_SHORT_THR: thr_short_q <= cfg.data;
        REG_LONG_THR:  thr_long_q  <= cfg.data;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_type_q   <= req.req_type;
      s1_levels_q <= req.button_levels;
      s1_time_q   <= req.time_now;
      s1_mask_q   <= req.button_mask;
    end
  end

  // Held time of each button and its class, modulo the time range
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      held_time[b] = s1_time_q - stamp_q[b];
      long_hit[b]  = CMP_W'(held_time[b]) >= CMP_W'(thr_long_q);
      short_hit[b] = CMP_W'(held_time[b]) >= CMP_W'(thr_short_q);
    end
  end

  // State update for the item in stage 1
  always_comb begin
    held_d   = held_q;
    short_d  = short_q;
    long_d   = long_q;
    stamp_we = '0;
    all_d    = 1'b0;
    unique case (req_type_e'(s1_type_q))
      REQ_SAMPLE: begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (s1_levels_q[b] && !held_q[b]) begin
            // press edge: remember when it went down
            stamp_we[b] = 1'b1;
            held_d[b]   = 1'b1;
          end else if (!s1_levels_q[b] && held_q[b]) begin
            // release edge: long wins over short, anything shorter is bounce
            if (long_hit[b]) begin
              long_d[b] = 1'b1;
            end else if (short_hit[b]) begin
              short_d[b] = 1'b1;
            end
            held_d[b] = 1'b0;
          end
        end
      end
      REQ_READ_SHORT: begin
        all_d   = (short_q & s1_mask_q) == s1_mask_q;
        short_d = short_q & ~s1_mask_q;
      end
      REQ_READ_LONG: begin
        all_d  = (long_q & s1_mask_q) == s1_mask_q;
        long_d = long_q & ~s1_mask_q;
      end
      default: begin
        all_d = 1'b0;
      end
    endcase
  end

  // Button state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      short_q <= '0;
      long_q  <= '0;
    end else if (adv) begin
      held_q  <= held_d;
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  // Press stamps, written on press edges only
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (adv && stamp_we[b]) begin
        stamp_q[b] <= s1_time_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_all_q   <= all_d;
      out_short_q <= short_d;
      out_long_q  <= long_d;
      out_held_q  <= held_d;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.all_flagged  = out_all_q;
  assign rsp.short_flags  = out_short_q;
  assign rsp.long_flags   = out_long_q;
  assign rsp.held_buttons = out_held_q;

endmodule

// File: rtl/bpdc_checker.sv
// Port-level checker of the button press duration classifier, bound to the top level.
`include "assert_macros.svh"

module bpdc_checker #(
  parameter int unsigned NUM_BUTTONS = bpdc_pkg::NUM_BUTTONS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   req_valid_i,
  input logic                   req_ready_i,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic                   rsp_all_i,
  input logic [NUM_BUTTONS-1:0] rsp_short_i,
  input logic [NUM_BUTTONS-1:0] rsp_long_i,
  input logic [NUM_BUTTONS-1:0] rsp_held_i,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_i
);
  logic req_acc;

  assign req_acc = req_valid_i && req_ready_i;

  // No result is pending as reset is released
  `BPDC_ASSERT_ALWAYS(a_rst_empty, clk_i, $rose(rst_ni) |-> !rsp_valid_i, "result valid out of reset")

  // A result that appears in an empty output comes from an accepted request item
  `BPDC_ASSERT(a_rsp_latency, clk_i, rst_ni, $rose(rsp_valid_i) |-> $past(req_acc, 2), "result without request")

  // A stalled result holds its payload
  `BPDC_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_all_i) && $stable(rsp_short_i) && $stable(rsp_long_i) && $stable(rsp_held_i), "stalled result changed")

  // Configuration writes are never held off
  `BPDC_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_i, "config write stalled")

endmodule

bind button_press_duration_classifier bpdc_checker #(
  .NUM_BUTTONS (NUM_BUTTONS)
) u_bpdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_all_i   (rsp.all_flagged),
  .rsp_short_i (rsp.short_flags),
  .rsp_long_i  (rsp.long_flags),
  .rsp_held_i  (rsp.held_buttons),
  .cfg_valid_i (cfg.valid),
  .cfg_ready_i (cfg.ready)
);
